[hw/rtl/lhp_pkg.sv]
// Shared constants and request/response types for the latency histogram.
// No dependencies; imported by the interfaces and all modules.
`timescale 1ns / 1ps

package lhp_pkg;

  localparam int SAMPLE_W        = 64;
  localparam int PCT_W           = 14;
  localparam int WIDTH_W         = 20;
  localparam int LINEAR_BINS_DEF = 64;
  localparam int LOG2_BINS_DEF   = 32;

  localparam logic [WIDTH_W-1:0] BIN_WIDTH_RST = 20'd1000;
  localparam logic [PCT_W-1:0]   PCT_FULL      = 14'd10000;

  // multiply-divide unit operand widths
  localparam int MD_A_W = SAMPLE_W + 1;
  localparam int MD_D_W = SAMPLE_W + 1;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic                start;
    logic [MD_A_W-1:0]   a;
    logic [SAMPLE_W-1:0] b;
    logic [MD_D_W-1:0]   dv;
  } md_req_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] q;
  } md_rsp_t;

endpackage

[hw/rtl/lhp_if.sv]
// Request and result channel interfaces (valid/ready with payload).
// Depends on lhp_pkg for field widths.
`timescale 1ns / 1ps

interface lhp_in_if import lhp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [SAMPLE_W-1:0] sample_ns;
  logic [PCT_W-1:0]    percent_hundredths;

  modport source (output valid, operation, sample_ns, percent_hundredths, input ready);
  modport sink   (input valid, operation, sample_ns, percent_hundredths, output ready);
endinterface

interface lhp_out_if import lhp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] percentile_ns;
  logic [SAMPLE_W-1:0] total_samples;
  logic [SAMPLE_W-1:0] max_sample_ns;

  modport source (output valid, percentile_ns, total_samples, max_sample_ns, input ready);
  modport sink   (input valid, percentile_ns, total_samples, max_sample_ns, output ready);
endinterface

[hw/rtl/lhp_muldiv.sv]
// Serial floor(a*b/dv): shift-add multiply, then restoring divide, one bit per cycle.
// Depends on lhp_pkg for md_req_t / md_rsp_t.
`timescale 1ns / 1ps

module lhp_muldiv import lhp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);

  localparam int P_W = MD_A_W + SAMPLE_W;   // full product width
  localparam int C_W = $clog2(P_W + 1);

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

  md_state_t           state_r;
  logic [MD_A_W-1:0]   a_r;
  logic [P_W-1:0]      b_r;
  logic [P_W-1:0]      prod_r;
  logic [MD_D_W-1:0]   dv_r;
  logic [MD_D_W-1:0]   rem_r;
  logic [SAMPLE_W-1:0] q_r;
  logic [C_W-1:0]      cnt_r;
  logic                done_r;
  logic [MD_D_W:0]     rem_sh;
  logic [MD_D_W:0]     rem_sub;
  logic                fits;

  assign rem_sh  = {rem_r, prod_r[P_W-1]};
  assign rem_sub = rem_sh - {1'b0, dv_r};
  assign fits    = rem_sh >= {1'b0, dv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        MD_IDLE: begin
          if (req.start) begin
            a_r     <= req.a;
            b_r     <= {{MD_A_W{1'b0}}, req.b};
            dv_r    <= req.dv;
            prod_r  <= '0;
            cnt_r   <= '0;
            state_r <= MD_MUL;
          end
        end
        MD_MUL: begin
          if (a_r[0]) prod_r <= prod_r + b_r;
          a_r   <= a_r >> 1;
          b_r   <= b_r << 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == C_W'(MD_A_W - 1)) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            q_r     <= '0;
            state_r <= MD_DIV;
          end
        end
        MD_DIV: begin
          rem_r  <= fits ? rem_sub[MD_D_W-1:0] : rem_sh[MD_D_W-1:0];
          q_r    <= {q_r[SAMPLE_W-2:0], fits};
          prod_r <= prod_r << 1;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == C_W'(P_W - 1)) begin
            done_r  <= 1'b1;
            state_r <= MD_IDLE;
          end
        end
        default: state_r <= MD_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule

[hw/rtl/latency_histogram_percentile.sv]
// Latency histogram with percentile queries; top level. Depends on lhp_pkg, lhp_if, lhp_muldiv.
// Record: serial bin divide (linear zone) or serial octave search (log zone), then a bin
//   read-modify-write (S_REC_RD, S_REC_WR).
// Query: target rank in the serial multiply-divide unit, bin walk (read, check per bin), then interpolation.
// One request in flight; results sit in an output register. Reset (sync, rst_n low)
//   clears per-bin valid flags, total and max at once, width to 1000; no clearing pass.
`timescale 1ns / 1ps

module latency_histogram_percentile import lhp_pkg::*; #(
  parameter int LINEAR_BINS = LINEAR_BINS_DEF,
  parameter int LOG2_BINS   = LOG2_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  lhp_in_if.sink             in_req,
  lhp_out_if.source          out_res,
  input  logic               cfg_wr_en,
  input  logic [WIDTH_W-1:0] cfg_wr_data
);

  localparam int NUM_BINS = LINEAR_BINS + LOG2_BINS;
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int QB       = (LINEAR_BINS > 1) ? $clog2(LINEAR_BINS) : 1;  // quotient bits
  localparam int QC_W     = $clog2(QB + 1);
  localparam int LM_W     = WIDTH_W + $clog2(LINEAR_BINS + 1);           // linear_max width
  localparam int LG_W     = $clog2(LOG2_BINS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LIN, S_LOG, S_REC_RD, S_REC_WR, S_TGT_W,
    S_WALK_RD, S_WALK_CHK, S_BOUNDS, S_INTERP_W
  } state_t;

  // saturating left shift of a bin bound
  function automatic logic [SAMPLE_W-1:0] shl_sat(input logic [SAMPLE_W-1:0] v,
                                                   input logic [6:0] k);
    logic [2*SAMPLE_W-1:0] t;
    t = {{SAMPLE_W{1'b0}}, v} << k;
    return (t[2*SAMPLE_W-1:SAMPLE_W] != '0) ? '1 : t[SAMPLE_W-1:0];
  endfunction

  state_t              state_r;
  logic [WIDTH_W-1:0]  bin_width_r;
  logic [WIDTH_W-1:0]  w_r;
  logic [LM_W-1:0]     lm_r;
  logic [LM_W-1:0]     rem_r;
  logic [QC_W-1:0]     bit_r;
  logic [SAMPLE_W-1:0] sh_r;
  logic [LG_W-1:0]     lg_r;
  logic [BIN_W-1:0]    bin_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] total_r;
  logic [SAMPLE_W-1:0] max_r;
  logic [SAMPLE_W-1:0] target_r;
  logic [SAMPLE_W-1:0] cum_r;
  logic [SAMPLE_W-1:0] pos_r;
  logic [SAMPLE_W-1:0] cnt_r;
  logic [SAMPLE_W-1:0] lo_r;
  logic                miss_r;
  logic [NUM_BINS-1:0] valid_r;

  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_pct_r;
  logic [SAMPLE_W-1:0] out_total_r;
  logic [SAMPLE_W-1:0] out_max_r;

  // bin count memory, registered read
  logic [SAMPLE_W-1:0] mem [NUM_BINS];
  logic [BIN_W-1:0]    rd_addr;
  logic [SAMPLE_W-1:0] rd_data_r;
  logic                rd_vld_r;
  logic                wr_en;
  logic [SAMPLE_W-1:0] wr_data;

  md_req_t md_req;
  md_rsp_t md_rsp;

  logic                accept;
  logic [WIDTH_W-1:0]  w_eff;
  logic [LM_W-1:0]     lm_eff;
  logic [PCT_W-1:0]    p_clamp;
  logic [LM_W-1:0]     trial;
  logic [SAMPLE_W-1:0] cur_cnt;
  logic [SAMPLE_W-1:0] need;
  logic [SAMPLE_W-1:0] lo_b, hi_b;
  logic [6:0]          k_b;
  logic [SAMPLE_W-1:0] tgt_q;

  assign in_req.ready = (state_r == S_IDLE) && !(out_valid_r && !out_res.ready);
  assign accept       = in_req.valid && in_req.ready;

  assign w_eff   = (bin_width_r == '0) ? WIDTH_W'(1) : bin_width_r;
  assign lm_eff  = LM_W'(LINEAR_BINS) * LM_W'(w_eff);
  assign p_clamp = (in_req.percent_hundredths > PCT_FULL) ? PCT_FULL
                                                          : in_req.percent_hundredths;
  assign trial   = LM_W'(w_r) << bit_r;
  assign cur_cnt = rd_vld_r ? rd_data_r : '0;
  assign need    = target_r - cum_r;

  // bin bounds for the bin the walk stopped on
  always_comb begin
    k_b = 7'(bin_r) - 7'(LINEAR_BINS);
    if (bin_r < BIN_W'(LINEAR_BINS)) begin
      lo_b = SAMPLE_W'(bin_r) * SAMPLE_W'(w_r);
      hi_b = (SAMPLE_W'(bin_r) + 1'b1) * SAMPLE_W'(w_r);
    end else begin
      lo_b = shl_sat(SAMPLE_W'(lm_r), k_b);
      hi_b = shl_sat(SAMPLE_W'(lm_r), k_b + 7'd1);
    end
  end

  assign tgt_q = (md_rsp.q == '0) ? SAMPLE_W'(1)
               : (md_rsp.q > total_r) ? total_r : md_rsp.q;

  // multiply-divide requests: target rank on query accept, interpolation at bounds
  always_comb begin
    md_req = '0;
    if (accept && in_req.operation == OP_QUERY && total_r != '0) begin
      md_req.start = 1'b1;
      md_req.a     = MD_A_W'(p_clamp);
      md_req.b     = total_r;
      md_req.dv    = MD_D_W'(PCT_FULL);
    end else if (state_r == S_BOUNDS && !miss_r) begin
      md_req.start = 1'b1;
      md_req.a     = {pos_r, 1'b0} - MD_A_W'(1);
      md_req.b     = hi_b - lo_b;
      md_req.dv    = {cnt_r, 1'b0};
    end
  end

  lhp_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  always_comb begin
    rd_addr = bin_r;
    wr_en   = (state_r == S_REC_WR);
    wr_data = cur_cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[bin_r] <= wr_data;
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bin_width_r <= BIN_WIDTH_RST;
      total_r     <= '0;
      max_r       <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) bin_width_r <= cfg_wr_data;
      if (out_valid_r && out_res.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            w_r      <= w_eff;
            lm_r     <= lm_eff;
            sample_r <= in_req.sample_ns;
            if (in_req.operation == OP_RECORD) begin
              if (in_req.sample_ns < SAMPLE_W'(lm_eff)) begin
                // sample < linear_max, so it fits LM_W bits
                rem_r   <= in_req.sample_ns[LM_W-1:0];
                bit_r   <= QC_W'(QB - 1);
                bin_r   <= '0;
                state_r <= S_LIN;
              end else begin
                sh_r    <= in_req.sample_ns >> 1;
                lg_r    <= '0;
                state_r <= S_LOG;
              end
            end else if (total_r == '0) begin
              // empty histogram answers 0 at once
              out_valid_r <= 1'b1;
              out_pct_r   <= '0;
              out_total_r <= total_r;
              out_max_r   <= max_r;
            end else begin
              state_r <= S_TGT_W;
            end
          end
        end

        // restoring divide of sample by width, one quotient bit a cycle
        S_LIN: begin
          if (rem_r >= trial) begin
            rem_r <= rem_r - trial;
            bin_r <= bin_r | (BIN_W'(1) << bit_r);
          end
          if (bit_r == '0) state_r <= S_REC_RD;
          else bit_r <= bit_r - 1'b1;
        end

        // octave search: advance while sample >> (k+1) still reaches linear_max
        S_LOG: begin
          if (sh_r >= SAMPLE_W'(lm_r) && lg_r < LG_W'(LOG2_BINS - 1)) begin
            lg_r <= lg_r + 1'b1;
            sh_r <= sh_r >> 1;
          end else begin
            bin_r   <= BIN_W'(LINEAR_BINS) + BIN_W'(lg_r);
            state_r <= S_REC_RD;
          end
        end

        S_REC_RD: state_r <= S_REC_WR;

        S_REC_WR: begin
          valid_r[bin_r] <= 1'b1;
          total_r        <= total_r + 1'b1;
          if (sample_r > max_r) max_r <= sample_r;
          out_valid_r <= 1'b1;
          out_pct_r   <= '0;
          out_total_r <= total_r + 1'b1;
          out_max_r   <= (sample_r > max_r) ? sample_r : max_r;
          state_r     <= S_IDLE;
        end

        S_TGT_W: begin
          if (md_rsp.done) begin
            target_r <= tgt_q;
            cum_r    <= '0;
            bin_r    <= '0;
            state_r  <= S_WALK_RD;
          end
        end

        S_WALK_RD: state_r <= S_WALK_CHK;

        S_WALK_CHK: begin
          if (cur_cnt != '0 && cur_cnt >= need) begin
            cnt_r   <= cur_cnt;
            pos_r   <= need;
            miss_r  <= 1'b0;
            state_r <= S_BOUNDS;
          end else begin
            cum_r <= cum_r + cur_cnt;
            if (bin_r == BIN_W'(NUM_BINS - 1)) begin
              // wrapped counters: answer is the last bin's lower bound
              miss_r  <= 1'b1;
              state_r <= S_BOUNDS;
            end else begin
              bin_r   <= bin_r + 1'b1;
              state_r <= S_WALK_RD;
            end
          end
        end

        S_BOUNDS: begin
          lo_r <= lo_b;
          if (miss_r) begin
            out_valid_r <= 1'b1;
            out_pct_r   <= lo_b;
            out_total_r <= total_r;
            out_max_r   <= max_r;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_INTERP_W;
          end
        end

        S_INTERP_W: begin
          if (md_rsp.done) begin
            out_valid_r <= 1'b1;
            out_pct_r   <= lo_r + md_rsp.q;
            out_total_r <= total_r;
            out_max_r   <= max_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.percentile_ns = out_pct_r;
  assign out_res.total_samples = out_total_r;
  assign out_res.max_sample_ns = out_max_r;

endmodule
